[src/msrc_pkg.sv]
package msrc_pkg;

   // Every configuration register is one byte wide.
   localparam int CFG_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int RUN_BITS = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MIP_LAYERS_NEEDED    = 3'd0,
      REG_SHOWER_LAYERS_NEEDED = 3'd1,
      REG_MAX_MISSED_LAYERS    = 3'd2,
      REG_MIN_MIP_TWO_SPAN     = 3'd3,
      REG_MAX_SHOWER_START_A   = 3'd4,
      REG_MIN_SHOWER_SPAN_A    = 3'd5,
      REG_MAX_SHOWER_START_B   = 3'd6,
      REG_MIN_SHOWER_SPAN_B    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] mip_layers_needed;
      logic [CFG_BITS-1:0] shower_layers_needed;
      logic [CFG_BITS-1:0] max_missed_layers;
      logic [CFG_BITS-1:0] min_mip_two_span;
      logic [CFG_BITS-1:0] max_shower_start_a;
      logic [CFG_BITS-1:0] min_shower_span_a;
      logic [CFG_BITS-1:0] max_shower_start_b;
      logic [CFG_BITS-1:0] min_shower_span_b;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mip_layers_needed:    8'd2,
      shower_layers_needed: 8'd2,
      max_missed_layers:    8'd1,
      min_mip_two_span:     8'd4,
      max_shower_start_a:   8'd20,
      min_shower_span_a:    8'd4,
      max_shower_start_b:   8'd5,
      min_shower_span_b:    8'd200
   };

   // Incremented run count, one bit wider than the counter, clamped to all ones.
   function automatic logic [RUN_BITS-1:0] sat_run(input logic [RUN_BITS:0] sum);
      return sum[RUN_BITS] ? {RUN_BITS{1'b1}} : sum[RUN_BITS-1:0];
   endfunction

endpackage

[src/msrc_cfg.sv]
module msrc_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [msrc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [msrc_pkg::CFG_BITS-1:0]        csr_wdata,
   output msrc_pkg::cfg_type                    cfg
);
   import msrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_MIP_LAYERS_NEEDED:    cfg_in.mip_layers_needed    = csr_wdata;
            REG_SHOWER_LAYERS_NEEDED: cfg_in.shower_layers_needed = csr_wdata;
            REG_MAX_MISSED_LAYERS:    cfg_in.max_missed_layers    = csr_wdata;
            REG_MIN_MIP_TWO_SPAN:     cfg_in.min_mip_two_span     = csr_wdata;
            REG_MAX_SHOWER_START_A:   cfg_in.max_shower_start_a   = csr_wdata;
            REG_MIN_SHOWER_SPAN_A:    cfg_in.min_shower_span_a    = csr_wdata;
            REG_MAX_SHOWER_START_B:   cfg_in.max_shower_start_b   = csr_wdata;
            REG_MIN_SHOWER_SPAN_B:    cfg_in.min_shower_span_b    = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/msrc_scan.sv]
module msrc_scan #(
   parameter int LAYER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msrc_pkg::cfg_type     cfg,
   input  logic                  step,
   input  logic [LAYER_BITS-1:0] layer,
   input  logic                  mip,
   input  logic                  shower,
   input  logic                  last,
   output logic                  fragment,
   output logic [LAYER_BITS-1:0] shower_start,
   output logic [LAYER_BITS-1:0] shower_end
);
   import msrc_pkg::*;

   localparam logic [LAYER_BITS-1:0] LAYER_NONE = {LAYER_BITS{1'b1}};
   localparam int CMP_BITS = (LAYER_BITS > CFG_BITS) ? LAYER_BITS : CFG_BITS;

   logic                  in_mip_one_ff, in_mip_one_in;
   logic                  in_mip_two_ff, in_mip_two_in;
   logic                  in_shower_ff, in_shower_in;
   logic                  stopped_ff, stopped_in;
   logic [RUN_BITS-1:0]   missed_ff, missed_in;
   logic [RUN_BITS-1:0]   mip_run_ff, mip_run_in;
   logic [RUN_BITS-1:0]   shower_run_ff, shower_run_in;
   logic [LAYER_BITS-1:0] mip_two_first_ff, mip_two_first_in;
   logic [LAYER_BITS-1:0] mip_two_last_ff, mip_two_last_in;
   logic [LAYER_BITS-1:0] shower_first_ff, shower_first_in;
   logic [LAYER_BITS-1:0] shower_last_ff, shower_last_in;

   logic [RUN_BITS:0]     missed_sum;
   logic [RUN_BITS:0]     mip_sum;
   logic [RUN_BITS:0]     shower_sum;
   logic [LAYER_BITS-1:0] shower_span;
   logic [LAYER_BITS-1:0] mip_span;
   logic                  end_ok;
   logic                  rule_a;
   logic                  rule_b;

   assign missed_sum = {1'b0, missed_ff} + 1'b1;
   assign mip_sum    = {1'b0, mip_run_ff} + 1'b1;
   assign shower_sum = {1'b0, shower_run_ff} + 1'b1;

   // Region walk for one layer. The region flags read here are the values before
   // this layer; the two run branches are exclusive, so no branch sees another's update.
   always_comb begin
      in_mip_one_in    = in_mip_one_ff;
      in_mip_two_in    = in_mip_two_ff;
      in_shower_in     = in_shower_ff;
      stopped_in       = stopped_ff;
      missed_in        = missed_ff;
      mip_run_in       = mip_run_ff;
      shower_run_in    = shower_run_ff;
      mip_two_first_in = mip_two_first_ff;
      mip_two_last_in  = mip_two_last_ff;
      shower_first_in  = shower_first_ff;
      shower_last_in   = shower_last_ff;

      if (!stopped_ff) begin
         if (mip || shower) begin
            missed_in = '0;
         end else begin
            missed_in = sat_run(missed_sum);
         end

         if (mip && in_mip_two_ff) begin
            mip_two_last_in = layer;
         end
         if (shower && in_shower_ff) begin
            shower_last_in = layer;
         end

         if (mip && !shower) begin
            if (in_mip_one_ff || in_mip_two_ff) begin
               shower_run_in = '0;
            end
            if (in_shower_ff) begin
               mip_run_in = sat_run(mip_sum);
               if (mip_sum == {1'b0, cfg.mip_layers_needed}) begin
                  in_mip_two_in = 1'b1;
                  in_shower_in  = 1'b0;
                  shower_run_in = '0;
               end else begin
                  mip_two_first_in = layer;
               end
            end
         end

         if (!mip && shower) begin
            if (in_shower_ff) begin
               mip_run_in = '0;
            end
            if (in_mip_one_ff || in_mip_two_ff) begin
               shower_run_in = sat_run(shower_sum);
               if (shower_sum == {1'b0, cfg.shower_layers_needed}) begin
                  if (in_mip_one_ff) begin
                     in_shower_in  = 1'b1;
                     in_mip_one_in = 1'b0;
                     shower_run_in = '0;
                  end
                  if (in_mip_two_ff) begin
                     stopped_in = 1'b1;
                  end
               end else if (in_mip_one_ff) begin
                  shower_first_in = layer;
               end
            end
         end

         // A saturated missed run stands for a count above every register value.
         if (missed_in == {RUN_BITS{1'b1}} || missed_in > cfg.max_missed_layers) begin
            stopped_in = 1'b1;
         end
      end
   end

   // Decision on the state as it stands after this layer.
   assign end_ok      = (shower_last_in != LAYER_NONE);
   assign shower_span = shower_last_in - shower_first_in;
   assign mip_span    = mip_two_last_in - mip_two_first_in;

   assign rule_a = (CMP_BITS'(mip_span) > CMP_BITS'(cfg.min_mip_two_span)) &&
                   (CMP_BITS'(shower_first_in) < CMP_BITS'(cfg.max_shower_start_a)) &&
                   end_ok &&
                   (CMP_BITS'(shower_span) > CMP_BITS'(cfg.min_shower_span_a));
   assign rule_b = (CMP_BITS'(shower_first_in) < CMP_BITS'(cfg.max_shower_start_b)) &&
                   end_ok &&
                   (CMP_BITS'(shower_span) > CMP_BITS'(cfg.min_shower_span_b));

   always_comb begin
      priority if (mip_two_last_in == LAYER_NONE) begin
         fragment = 1'b0;
      end else if (end_ok && shower_first_in == LAYER_NONE) begin
         fragment = 1'b1;
      end else begin
         fragment = rule_a || rule_b;
      end
   end

   assign shower_start = shower_first_in;
   assign shower_end   = shower_last_in;

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         in_mip_one_ff    <= 1'b1;
         in_mip_two_ff    <= 1'b0;
         in_shower_ff     <= 1'b0;
         stopped_ff       <= 1'b0;
         missed_ff        <= '0;
         mip_run_ff       <= '0;
         shower_run_ff    <= '0;
         mip_two_first_ff <= LAYER_NONE;
         mip_two_last_ff  <= LAYER_NONE;
         shower_first_ff  <= LAYER_NONE;
         shower_last_ff   <= LAYER_NONE;
      end else if (step) begin
         in_mip_one_ff    <= in_mip_one_in;
         in_mip_two_ff    <= in_mip_two_in;
         in_shower_ff     <= in_shower_in;
         stopped_ff       <= stopped_in;
         missed_ff        <= missed_in;
         mip_run_ff       <= mip_run_in;
         shower_run_ff    <= shower_run_in;
         mip_two_first_ff <= mip_two_first_in;
         mip_two_last_ff  <= mip_two_last_in;
         shower_first_ff  <= shower_first_in;
         shower_last_ff   <= shower_last_in;
      end
   end

endmodule

[src/mip_shower_region_classifier_core.sv]
// An accepted word is held in the input register and scanned from there; the result of a
// last word is then held in the result register, from which rsp_ offers it.
// Throughput: one word per cycle, sustained while the result side keeps up. A last word
// waits in the input register only while the result register still holds an untaken word.
// Reset (synchronous, active high) restores the register defaults and the cluster state.
module mip_shower_region_classifier_core #(
   parameter int  LAYER_BITS = 8,
   localparam int REQ_DATA_BITS = ((LAYER_BITS + 2 + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2 * LAYER_BITS + 1 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input words, one per calorimeter layer.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: layer_number, mip_hit, shower_hit, zero fill.
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,
   // Marks the cluster's outermost layer.
   input  logic                                req_tlast,
   // Result words, one per cluster.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: fragment, shower_start, shower_end, zero fill.
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,
   // Register write port.
   input  logic                                csr_wr_en,
   input  logic [msrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [msrc_pkg::CFG_BITS-1:0]       csr_wdata
);
   import msrc_pkg::*;

   cfg_type cfg;

   // Input register: holds one accepted layer word until the scan consumes it.
   logic                  s1_valid_ff, s1_valid_in;
   logic [LAYER_BITS-1:0] s1_layer_ff;
   logic                  s1_mip_ff;
   logic                  s1_shower_ff;
   logic                  s1_last_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fragment_ff;
   logic [LAYER_BITS-1:0] rsp_start_ff;
   logic [LAYER_BITS-1:0] rsp_end_ff;

   logic                  out_free;
   logic                  s1_fire;
   logic                  req_fire;
   logic                  scan_fragment;
   logic [LAYER_BITS-1:0] scan_start;
   logic [LAYER_BITS-1:0] scan_end;

   msrc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The word in the input register is scanned when it causes no result, or when the
   // result register is empty or being emptied in this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_fire  = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   msrc_scan #(
      .LAYER_BITS (LAYER_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (s1_fire),
      .layer        (s1_layer_ff),
      .mip          (s1_mip_ff),
      .shower       (s1_shower_ff),
      .last         (s1_last_ff),
      .fragment     (scan_fragment),
      .shower_start (scan_start),
      .shower_end   (scan_end)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_layer_ff  <= req_tdata[LAYER_BITS-1:0];
         s1_mip_ff    <= req_tdata[LAYER_BITS];
         s1_shower_ff <= req_tdata[LAYER_BITS+1];
         s1_last_ff   <= req_tlast;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_fragment_ff <= scan_fragment;
         rsp_start_ff    <= scan_start;
         rsp_end_ff      <= scan_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0] = rsp_fragment_ff;
      rsp_tdata[LAYER_BITS:1] = rsp_start_ff;
      rsp_tdata[2*LAYER_BITS:LAYER_BITS+1] = rsp_end_ff;
   end

endmodule

[src/msrc_checker.sv]
module msrc_checker #(
   parameter int  LAYER_BITS = 8,
   localparam int RSP_DATA_BITS = ((2 * LAYER_BITS + 1 + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam logic [LAYER_BITS-1:0] LAYER_NONE = {LAYER_BITS{1'b1}};

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // No result word is left over from before reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The input side stalls only behind an untaken result word.
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a blocked result");

   // Every path to a fragment decision needs a shower end layer.
   a_fragment_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2*LAYER_BITS:LAYER_BITS+1] != LAYER_NONE)
      else $error("fragment decision without shower end");

endmodule

bind mip_shower_region_classifier_core msrc_checker #(
   .LAYER_BITS (LAYER_BITS)
) u_msrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
